// File: rtl/mer_pkg.sv
// Shared types and constants for the midpoint ellipse rasterizer.
package mer_pkg;

    // Quadrant index of one emitted pixel: bit 0 negates x, bit 1 negates y.
    typedef logic [1:0] quad_t;

    localparam quad_t QUAD_FIRST = 2'd0;
    localparam quad_t QUAD_LAST  = 2'd3;

    // Command codes on the input channel.
    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

endpackage

// File: rtl/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer: command sequencer and walk state.
//
// A start transaction (cmd 0) latches the centre and semi-axes and runs the
// setup in ST_START, in which one shared multiplier forms rx^2, ry^2 and
// 2*rx^2*ry; if the walk begins in region two, ST_SEED then uses the multiplier
// to seed the region-two decision. An advance transaction (cmd 1) produces the
// four quadrant pixel transactions (+x,+y), (-x,+y), (+x,-y), (-x,-y), one per
// cycle while pix_stall is low, through a single output register, the fourth
// marked last_of_point, then, unless it was the last point, steps the point in
// ST_STEP_A and ST_STEP_B, with ST_SEED after them on the advance that enters
// region two. A new start or advance is taken only once the last one is through.
// The walk ends on the y = 0 point of region two, whose last pixel carries finished.
// An advance with no ellipse in progress is accepted and produces nothing.
// item_stall is high whenever the sequencer is busy.
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           cmd,
    input  logic [COORD_BITS-1:0]          centre_x,
    input  logic [COORD_BITS-1:0]          centre_y,
    input  logic [RADIUS_BITS-1:0]         radius_x,
    input  logic [RADIUS_BITS-1:0]         radius_y,
    output logic                           pix_valid,
    input  logic                           pix_stall,
    output logic signed [COORD_BITS+1:0]   pix_x,
    output logic signed [COORD_BITS+1:0]   pix_y,
    output logic                           last_of_point,
    output logic                           finished
);
    import mer_pkg::*;

    localparam int SQ_BITS   = 2 * RADIUS_BITS;
    localparam int STEP_BITS = 3 * RADIUS_BITS + 2;
    localparam int DEC_BITS  = 4 * RADIUS_BITS + 2;
    localparam int A_BITS    = 3 * RADIUS_BITS;
    localparam int B_BITS    = 2 * RADIUS_BITS;
    localparam int P_BITS    = A_BITS + B_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SEED,
        ST_EMIT,
        ST_STEP_A,
        ST_STEP_B
    } state_t;

    typedef logic [2:0] phase_t;

    state_t                 state_reg, state_next;
    phase_t                 ph_reg, ph_next;
    quad_t                  quad_reg, quad_next;
    logic                   active_reg, active_next;
    logic                   r2_reg, r2_next;
    logic                   br_reg, br_next;
    logic [COORD_BITS-1:0]  ctr_x_reg, ctr_x_next;
    logic [COORD_BITS-1:0]  ctr_y_reg, ctr_y_next;
    logic [RADIUS_BITS-1:0] rad_x_reg, rad_x_next;
    logic [RADIUS_BITS-1:0] rad_y_reg, rad_y_next;
    logic [SQ_BITS-1:0]     rad_x_sq_reg, rad_x_sq_next;
    logic [SQ_BITS-1:0]     rad_y_sq_reg, rad_y_sq_next;
    logic [RADIUS_BITS-1:0] cur_x_reg, cur_x_next;
    logic [RADIUS_BITS-1:0] cur_y_reg, cur_y_next;
    logic [STEP_BITS-1:0]   step_x_reg, step_x_next;
    logic [STEP_BITS-1:0]   step_y_reg, step_y_next;
    logic [DEC_BITS-1:0]    dec_reg, dec_next;
    logic [DEC_BITS-1:0]    acc_reg, acc_next;

    logic [A_BITS-1:0]      op_a;
    logic [B_BITS-1:0]      op_b;
    logic [P_BITS-1:0]      prod;

    logic                   pix_free;
    logic                   pix_load;
    logic                   fin_point;
    logic [STEP_BITS-1:0]   two_rx_sq;
    logic [STEP_BITS-1:0]   two_ry_sq;
    logic [STEP_BITS-1:0]   start_step_y;
    logic                   dec_neg;
    logic                   dec_pos;
    logic                   use_x;
    logic                   use_y;
    logic [DEC_BITS-1:0]    dec_term;

    mer_mult #(
        .A_BITS (A_BITS),
        .B_BITS (B_BITS)
    ) u_mult (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    mer_pix_out #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_pix_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (pix_load),
        .quad          (quad_reg),
        .fin           (fin_point),
        .ctr_x         (ctr_x_reg),
        .ctr_y         (ctr_y_reg),
        .cur_x         (cur_x_reg),
        .cur_y         (cur_y_reg),
        .free          (pix_free),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .pix_x         (pix_x),
        .pix_y         (pix_y),
        .last_of_point (last_of_point),
        .finished      (finished)
    );

    assign item_stall = (state_reg != ST_IDLE);
    assign pix_load   = (state_reg == ST_EMIT) && pix_free;
    assign fin_point  = r2_reg && (cur_y_reg == '0);

    assign two_rx_sq    = {(STEP_BITS-SQ_BITS-1)'(0), rad_x_sq_reg, 1'b0};
    assign two_ry_sq    = {(STEP_BITS-SQ_BITS-1)'(0), rad_y_sq_reg, 1'b0};
    assign start_step_y = {(STEP_BITS-A_BITS-1)'(0), prod[A_BITS-1:0], 1'b0};
    assign dec_neg      = dec_reg[DEC_BITS-1];
    assign dec_pos      = !dec_reg[DEC_BITS-1] && (dec_reg != '0);

    // Region one always moves x and moves y on the taken branch; region two the reverse.
    assign use_x = r2_reg ? br_reg : 1'b1;
    assign use_y = r2_reg ? 1'b1 : br_reg;

    always_comb
    begin
        dec_term = r2_reg ? DEC_BITS'(rad_x_sq_reg) : DEC_BITS'(rad_y_sq_reg);
        if (use_x)
            dec_term = dec_term + DEC_BITS'(step_x_reg);
        if (use_y)
            dec_term = dec_term - DEC_BITS'(step_y_reg);
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            ST_START:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        op_a = A_BITS'(rad_x_reg);
                        op_b = B_BITS'(rad_x_reg);
                    end
                    3'd1:
                    begin
                        op_a = A_BITS'(rad_y_reg);
                        op_b = B_BITS'(rad_y_reg);
                    end
                    3'd2:
                    begin
                        op_a = A_BITS'(rad_x_sq_reg);
                        op_b = B_BITS'(rad_y_reg);
                    end
                    default:
                    begin
                        op_a = '0;
                        op_b = '0;
                    end
                endcase
            end
            ST_SEED:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        op_a = A_BITS'(rad_y_sq_reg);
                        op_b = B_BITS'(cur_x_reg);
                    end
                    3'd1:
                    begin
                        op_a = prod[A_BITS-1:0];
                        op_b = B_BITS'(cur_x_reg);
                    end
                    3'd2:
                    begin
                        op_a = A_BITS'(rad_x_sq_reg);
                        op_b = B_BITS'(cur_y_reg);
                    end
                    3'd3:
                    begin
                        op_a = prod[A_BITS-1:0];
                        op_b = B_BITS'(cur_y_reg);
                    end
                    3'd4:
                    begin
                        op_a = A_BITS'(rad_x_sq_reg);
                        op_b = rad_y_sq_reg;
                    end
                    default:
                    begin
                        op_a = '0;
                        op_b = '0;
                    end
                endcase
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        ph_next       = ph_reg;
        quad_next     = quad_reg;
        active_next   = active_reg;
        r2_next       = r2_reg;
        br_next       = br_reg;
        ctr_x_next    = ctr_x_reg;
        ctr_y_next    = ctr_y_reg;
        rad_x_next    = rad_x_reg;
        rad_y_next    = rad_y_reg;
        rad_x_sq_next = rad_x_sq_reg;
        rad_y_sq_next = rad_y_sq_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        step_x_next   = step_x_reg;
        step_y_next   = step_y_reg;
        dec_next      = dec_reg;
        acc_next      = acc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (cmd == CMD_START)
                    begin
                        ctr_x_next  = centre_x;
                        ctr_y_next  = centre_y;
                        rad_x_next  = radius_x;
                        rad_y_next  = radius_y;
                        cur_x_next  = '0;
                        cur_y_next  = radius_y;
                        step_x_next = '0;
                        r2_next     = 1'b0;
                        active_next = 1'b1;
                        ph_next     = '0;
                        state_next  = ST_START;
                    end
                    else if (active_reg)
                    begin
                        quad_next  = QUAD_FIRST;
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_START:
            begin
                ph_next = ph_reg + 3'd1;
                case (ph_reg)
                    3'd1:
                        rad_x_sq_next = prod[SQ_BITS-1:0];
                    3'd2:
                        rad_y_sq_next = prod[SQ_BITS-1:0];
                    3'd3:
                    begin
                        step_y_next = start_step_y;
                        dec_next = DEC_BITS'(rad_y_sq_reg) - DEC_BITS'(prod[A_BITS-1:0])
                                 + DEC_BITS'(rad_x_sq_reg >> 2);
                        ph_next = '0;
                        // step_x starts at zero, so region two is due only if step_y is zero.
                        if (start_step_y == '0)
                            state_next = ST_SEED;
                        else
                            state_next = ST_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_SEED:
            begin
                ph_next = ph_reg + 3'd1;
                case (ph_reg)
                    3'd2:
                        acc_next = prod[DEC_BITS-1:0];
                    3'd4:
                        acc_next = acc_reg + prod[DEC_BITS-1:0];
                    3'd5:
                    begin
                        dec_next   = acc_reg - prod[DEC_BITS-1:0];
                        r2_next    = 1'b1;
                        ph_next    = '0;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                    end
                endcase
            end

            ST_EMIT:
            begin
                if (pix_free)
                begin
                    quad_next = quad_reg + 2'd1;
                    if (quad_reg == QUAD_LAST)
                    begin
                        if (fin_point)
                        begin
                            active_next = 1'b0;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_STEP_A;
                        end
                    end
                end
            end

            ST_STEP_A:
            begin
                if (!r2_reg)
                begin
                    step_x_next = step_x_reg + two_ry_sq;
                    cur_x_next  = cur_x_reg + 1'b1;
                    br_next     = !dec_neg;
                    if (!dec_neg)
                    begin
                        cur_y_next  = cur_y_reg - 1'b1;
                        step_y_next = step_y_reg - two_rx_sq;
                    end
                end
                else
                begin
                    step_y_next = step_y_reg - two_rx_sq;
                    cur_y_next  = cur_y_reg - 1'b1;
                    br_next     = !dec_pos;
                    if (!dec_pos)
                    begin
                        cur_x_next  = cur_x_reg + 1'b1;
                        step_x_next = step_x_reg + two_ry_sq;
                    end
                end
                state_next = ST_STEP_B;
            end

            ST_STEP_B:
            begin
                dec_next = dec_reg + dec_term;
                ph_next  = '0;
                if (!r2_reg && (step_x_reg >= step_y_reg))
                    state_next = ST_SEED;
                else
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ph_reg       <= '0;
            quad_reg     <= QUAD_FIRST;
            active_reg   <= 1'b0;
            r2_reg       <= 1'b0;
            br_reg       <= 1'b0;
            ctr_x_reg    <= '0;
            ctr_y_reg    <= '0;
            rad_x_reg    <= '0;
            rad_y_reg    <= '0;
            rad_x_sq_reg <= '0;
            rad_y_sq_reg <= '0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            step_x_reg   <= '0;
            step_y_reg   <= '0;
            dec_reg      <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ph_reg       <= ph_next;
            quad_reg     <= quad_next;
            active_reg   <= active_next;
            r2_reg       <= r2_next;
            br_reg       <= br_next;
            ctr_x_reg    <= ctr_x_next;
            ctr_y_reg    <= ctr_y_next;
            rad_x_reg    <= rad_x_next;
            rad_y_reg    <= rad_y_next;
            rad_x_sq_reg <= rad_x_sq_next;
            rad_y_sq_reg <= rad_y_sq_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            step_x_reg   <= step_x_next;
            step_y_reg   <= step_y_next;
            dec_reg      <= dec_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

// File: rtl/mer_mult.sv
// Shared unsigned multiplier with a registered product.
module mer_mult #(
    parameter int A_BITS = 30,
    parameter int B_BITS = 20
) (
    input  logic                       clk,
    input  logic [A_BITS-1:0]          op_a,
    input  logic [B_BITS-1:0]          op_b,
    output logic [A_BITS+B_BITS-1:0]   prod
);

    logic [A_BITS+B_BITS-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= (A_BITS+B_BITS)'(op_a) * (A_BITS+B_BITS)'(op_b);
    end

    assign prod = prod_reg;

endmodule

// File: rtl/mer_pix_out.sv
// Pixel generator and output register for the four quadrant pixels of a point.
module mer_pix_out #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  mer_pkg::quad_t                 quad,
    input  logic                           fin,
    input  logic [COORD_BITS-1:0]          ctr_x,
    input  logic [COORD_BITS-1:0]          ctr_y,
    input  logic [RADIUS_BITS-1:0]         cur_x,
    input  logic [RADIUS_BITS-1:0]         cur_y,
    output logic                           free,
    output logic                           pix_valid,
    input  logic                           pix_stall,
    output logic signed [COORD_BITS+1:0]   pix_x,
    output logic signed [COORD_BITS+1:0]   pix_y,
    output logic                           last_of_point,
    output logic                           finished
);
    import mer_pkg::*;

    localparam int PIX_BITS = COORD_BITS + 2;
    localparam int EXT_BITS = (PIX_BITS > RADIUS_BITS) ? PIX_BITS : RADIUS_BITS;

    logic                valid_reg;
    logic [PIX_BITS-1:0] pix_x_reg;
    logic [PIX_BITS-1:0] pix_y_reg;
    logic                last_reg;
    logic                fin_reg;

    logic [EXT_BITS-1:0] sum_x;
    logic [EXT_BITS-1:0] sum_y;
    logic                last_now;

    // The register can take a new pixel when empty or when its pixel leaves now.
    assign free = !valid_reg || !pix_stall;

    always_comb
    begin
        if (quad[0])
            sum_x = EXT_BITS'(ctr_x) - EXT_BITS'(cur_x);
        else
            sum_x = EXT_BITS'(ctr_x) + EXT_BITS'(cur_x);
        if (quad[1])
            sum_y = EXT_BITS'(ctr_y) - EXT_BITS'(cur_y);
        else
            sum_y = EXT_BITS'(ctr_y) + EXT_BITS'(cur_y);
        last_now = (quad == QUAD_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!pix_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_x_reg <= sum_x[PIX_BITS-1:0];
            pix_y_reg <= sum_y[PIX_BITS-1:0];
            last_reg  <= last_now;
            fin_reg   <= last_now && fin;
        end
    end

    assign pix_valid     = valid_reg;
    assign pix_x         = pix_x_reg;
    assign pix_y         = pix_y_reg;
    assign last_of_point = last_reg;
    assign finished      = fin_reg;

endmodule
